[rtl/core/dpa_pkg.sv]
// shared constants, types and arithmetic helpers for the director averaging block
`default_nettype none
package dpa_pkg;

  localparam int FRAC_BITS = 30;
  localparam int DW  = 32;   // director component
  localparam int XW  = 36;   // rounded cross and triple products
  localparam int NW  = 40;   // numerator sum
  localparam int MW  = 33;   // multiplier operand
  localparam int PW  = 66;   // multiplier product and accumulator
  localparam int LW  = 64;   // squared cross length
  localparam int XAW = 108;  // scaled dividend
  localparam int QW  = 41;   // quotient bits before the cap
  localparam int CW  = 6;    // divider step counter
  localparam int LIMW = 63;  // threshold registers
  localparam int AW  = 4;    // configuration address
  localparam int PDW = 64;   // configuration data

  localparam logic [AW-1:0] REG_PARALLEL = AW'(0);
  localparam logic [AW-1:0] REG_SINGULAR = AW'(8);

  localparam logic [LIMW-1:0] PARALLEL_RST = LIMW'(1152922);
  localparam logic [LIMW-1:0] SINGULAR_RST = LIMW'(115292);

  localparam logic [QW-1:0] QCAP = QW'(1) << (QW - 1);

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // round half up to FRAC_BITS fraction bits
  function automatic logic signed [XW-1:0] rnd_shift(input logic signed [PW-1:0] x);
    logic signed [PW:0] t;
    logic signed [PW:0] s;
    t = $signed({x[PW-1], x}) + ($signed((PW+1)'(1)) <<< (FRAC_BITS - 1));
    s = t >>> FRAC_BITS;
    return s[XW-1:0];
  endfunction

  function automatic logic [1:0] nxt3(input logic [1:0] j);
    return (j == 2'd2) ? 2'd0 : j + 2'd1;
  endfunction

endpackage
`default_nettype wire

[rtl/core/dpa_in_if.sv]
// input channel: one director vector per transaction
`default_nettype none
interface dpa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic               last_dir;

  modport source (output valid, dir_x, dir_y, dir_z, last_dir, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, last_dir, output ready);
endinterface
`default_nettype wire

[rtl/core/dpa_out_if.sv]
// result channel: averaged director and run flags
`default_nettype none
interface dpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] avg_x;
  logic signed [31:0] avg_y;
  logic signed [31:0] avg_z;
  logic               failed;
  logic               saturated;

  modport source (output valid, avg_x, avg_y, avg_z, failed, saturated, input ready);
  modport sink   (input valid, avg_x, avg_y, avg_z, failed, saturated, output ready);
endinterface
`default_nettype wire

[rtl/core/dpa_div.sv]
// restoring divider, one quotient bit a cycle, capped quotient
`default_nettype none
module dpa_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dpa_pkg::div_ctl_t       ctl,
  input  wire logic [dpa_pkg::XAW-1:0] numer,
  input  wire logic [dpa_pkg::LW-1:0]  denom,
  output dpa_pkg::div_stat_t           stat,
  output logic [dpa_pkg::QW-1:0]       quot
);
  import dpa_pkg::*;

  logic [LW-1:0] rem_r;
  logic [QW-1:0] lo_r;
  logic [QW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [LW:0]   trial;
  logic          ge;
  logic [XAW-QW-1:0] top;

  assign top   = numer[XAW-1:QW];
  assign trial = {rem_r, lo_r[QW-1]};
  assign ge    = trial >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        // quotient at or beyond 2^QW goes straight to the cap
        if (top >= (XAW-QW)'(denom)) begin
          q_r    <= QCAP;
          done_r <= 1'b1;
        end else begin
          rem_r  <= top[LW-1:0];
          lo_r   <= numer[QW-1:0];
          q_r    <= '0;
          cnt_r  <= CW'(QW);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? LW'(trial - {1'b0, denom}) : trial[LW-1:0];
        lo_r  <= {lo_r[QW-2:0], 1'b0};
        q_r   <= {q_r[QW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = (q_r > QCAP) ? QCAP : q_r;

endmodule
`default_nettype wire

[rtl/core/director_pair_averaging.sv]
// running director averaging over runs of 3d director vectors
//
//  channel  | direction | handshake              | payload
//  in_ch    | in        | valid/ready            | dir_x, dir_y, dir_z, last_dir
//  out_ch   | out       | valid/ready            | avg_x, avg_y, avg_z, failed, saturated
//  cfg_*    | in        | apb write/read, pready | parallel_limit @0, singular_limit @8
//
// first vector of a run becomes the running director; later vectors form cross products
// and squared length, then a parallel step takes the midpoint, a singular step stops,
// a general step is dominated by three divisions (one shared 33x33 multiplier does
// every product); a capped quotient skips its division steps; a last vector adds S_OUT
// rst_n is synchronous; thresholds return to their reset values
// a result waiting on out_ch does not stop the next transaction from being taken;
// only the completion of the following last vector waits for the output slot
`default_nettype none
module director_pair_averaging (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  dpa_in_if.sink                       in_ch,
  dpa_out_if.source                    out_ch,
  input  wire logic                    cfg_psel,
  input  wire logic                    cfg_penable,
  input  wire logic                    cfg_pwrite,
  input  wire logic [dpa_pkg::AW-1:0]  cfg_paddr,
  input  wire logic [dpa_pkg::PDW-1:0] cfg_pwdata,
  output logic [dpa_pkg::PDW-1:0]      cfg_prdata,
  output logic                         cfg_pready
);
  import dpa_pkg::*;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_XC   = 4'd1;  // cross products a x d, then a x cs
  localparam logic [3:0] S_LEN  = 4'd2;  // squared cross length
  localparam logic [3:0] S_DEC  = 4'd3;  // parallel / singular / general
  localparam logic [3:0] S_MID  = 4'd4;  // midpoint
  localparam logic [3:0] S_NUM  = 4'd5;  // a.d - |d|^2
  localparam logic [3:0] S_DP   = 4'd6;  // |n|*|v_k| partial products
  localparam logic [3:0] S_DIV  = 4'd7;  // start divider
  localparam logic [3:0] S_DW   = 4'd8;  // wait divider, form new component
  localparam logic [3:0] S_CMT  = 4'd9;  // commit new director
  localparam logic [3:0] S_OUT  = 4'd10; // hand result to output register

  logic [3:0] st_r, st_nxt;

  // configuration
  logic [LIMW-1:0] plim_r, slim_r;
  logic            cfg_wr;

  // run state
  logic signed [DW-1:0] run_r [3];
  logic                 have_first_r, fail_seen_r, clip_seen_r;

  // working registers
  logic signed [DW-1:0] d_r  [3];
  logic                 last_r;
  logic signed [XW-1:0] c_r  [3];
  logic signed [XW-1:0] v_r  [3];
  logic signed [DW-1:0] nx_r [3];
  logic signed [NW-1:0] nsum_r;
  logic [LW-1:0]        len_r;
  logic signed [PW-1:0] acc_r;
  logic [XAW-1:0]       xacc_r;
  logic [1:0]           j_r, cnt_r;
  logic                 ph_r, use_v_r;

  // output register
  logic                 out_valid_r;
  logic signed [DW-1:0] avg_r [3];
  logic                 failed_r, saturated_r;

  // shared multiplier
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] mul_p;
  logic signed [XW-1:0] rnd_v;

  logic [1:0]           j1, j2;
  logic signed [DW-1:0] cs [3];
  logic [2:0]           c_clip;
  logic signed [DW-1:0] bsel [3];
  logic [XW-1:0]        cmag;
  logic [LW-1:0]        sq;
  logic [LW:0]          len_sum;
  logic [NW-1:0]        nmag;
  logic [XW-1:0]        vmag;
  logic [XAW-1:0]       part;
  logic                 neg;
  logic signed [DW+9:0] upd;
  logic                 upd_clip;
  logic signed [DW:0]   mid [3];

  div_ctl_t         div_ctl;
  div_stat_t        div_stat;
  logic [QW-1:0]    quot;

  logic in_acc, out_acc, out_free;

  assign in_ch.ready = (st_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_valid_r && out_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // apb: byte address 8*i, low address bits ignored
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[3] ? {1'b0, slim_r} : {1'b0, plim_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plim_r <= PARALLEL_RST;
      slim_r <= SINGULAR_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[3] == REG_SINGULAR[3]) slim_r <= cfg_pwdata[LIMW-1:0];
      else                                 plim_r <= cfg_pwdata[LIMW-1:0];
    end
  end

  // operand selection
  assign j1 = nxt3(j_r);
  assign j2 = nxt3(j1);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_clip[k] = !((c_r[k][XW-1:DW-1] == '0) || (c_r[k][XW-1:DW-1] == '1));
      if (!c_clip[k])       cs[k] = c_r[k][DW-1:0];
      else if (c_r[k][XW-1]) cs[k] = {1'b1, {(DW-1){1'b0}}};
      else                  cs[k] = {1'b0, {(DW-1){1'b1}}};
      bsel[k] = use_v_r ? cs[k] : d_r[k];
      mid[k]  = ($signed({run_r[k][DW-1], run_r[k]}) + $signed({d_r[k][DW-1], d_r[k]})) >>> 1;
    end
  end

  assign cmag = c_r[j_r][XW-1] ? XW'(-c_r[j_r]) : XW'(c_r[j_r]);
  assign nmag = nsum_r[NW-1] ? NW'(-nsum_r) : NW'(nsum_r);
  assign vmag = v_r[j_r][XW-1] ? XW'(-v_r[j_r]) : XW'(v_r[j_r]);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (st_r)
      S_XC: begin
        if (!ph_r) begin
          op_a = MW'(run_r[j1]);
          op_b = MW'(bsel[j2]);
        end else begin
          op_a = MW'(run_r[j2]);
          op_b = MW'(bsel[j1]);
        end
      end
      S_LEN: begin
        op_a = {1'b0, cmag[DW-1:0]};
        op_b = {1'b0, cmag[DW-1:0]};
      end
      S_NUM: begin
        op_a = ph_r ? MW'(d_r[j_r]) : MW'(run_r[j_r]);
        op_b = MW'(d_r[j_r]);
      end
      S_DP: begin
        op_a = cnt_r[1] ? MW'(nmag[NW-1:DW]) : {1'b0, nmag[DW-1:0]};
        op_b = cnt_r[0] ? MW'(vmag[XW-1:DW]) : {1'b0, vmag[DW-1:0]};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_p = op_a * op_b;
  assign rnd_v = rnd_shift(acc_r - mul_p);

  // squared component saturates once the magnitude leaves 32 bits
  assign sq      = (cmag[XW-1:DW] != '0) ? '1 : LW'(mul_p);
  assign len_sum = {1'b0, len_r} + {1'b0, sq};

  // partial product weight: n0v0 at 0, cross terms at 32, n1v1 at 64
  always_comb begin
    part = XAW'(mul_p[LW-1:0]) << FRAC_BITS;
    if (cnt_r == 2'd3)      part = part << (2 * DW);
    else if (cnt_r != 2'd0) part = part << DW;
  end

  // new component: a_k +/- q, clipped to 32 bits
  assign neg      = nsum_r[NW-1] ^ v_r[j_r][XW-1];
  assign upd      = $signed((DW+10)'(run_r[j_r]))
                    + (neg ? -$signed((DW+10)'(quot)) : $signed((DW+10)'(quot)));
  assign upd_clip = !((upd[DW+9:DW-1] == '0) || (upd[DW+9:DW-1] == '1));

  assign div_ctl.start = (st_r == S_DIV);

  dpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .numer (xacc_r),
    .denom (len_r),
    .stat  (div_stat),
    .quot  (quot)
  );

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_acc) st_nxt = have_first_r ? S_XC : (in_ch.last_dir ? S_OUT : S_IDLE);
      S_XC:   if (ph_r && j_r == 2'd2) st_nxt = use_v_r ? S_NUM : S_LEN;
      S_LEN:  if (j_r == 2'd2) st_nxt = S_DEC;
      S_DEC: begin
        if (len_r <= {1'b0, plim_r})                      st_nxt = S_MID;
        else if (len_r <= {1'b0, slim_r} || len_r == '0) st_nxt = last_r ? S_OUT : S_IDLE;
        else                                              st_nxt = S_XC;
      end
      S_MID:  st_nxt = last_r ? S_OUT : S_IDLE;
      S_NUM:  if (ph_r && j_r == 2'd2) st_nxt = S_DP;
      S_DP:   if (cnt_r == 2'd3) st_nxt = S_DIV;
      S_DIV:  st_nxt = S_DW;
      S_DW:   if (div_stat.done) st_nxt = (j_r == 2'd2) ? S_CMT : S_DP;
      S_CMT:  st_nxt = last_r ? S_OUT : S_IDLE;
      S_OUT:  if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      have_first_r <= 1'b0;
      fail_seen_r  <= 1'b0;
      clip_seen_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 3; k++) run_r[k] <= '0;
    end else begin
      st_r <= st_nxt;
      // output slot fills from the hand-over state, empties on a taken transaction
      if (st_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_acc)              out_valid_r <= 1'b0;

      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            d_r[0] <= in_ch.dir_x;
            d_r[1] <= in_ch.dir_y;
            d_r[2] <= in_ch.dir_z;
            last_r <= in_ch.last_dir;
            j_r    <= 2'd0;
            ph_r   <= 1'b0;
            use_v_r <= 1'b0;
            // first vector of a run becomes the running director
            if (!have_first_r) begin
              run_r[0]     <= in_ch.dir_x;
              run_r[1]     <= in_ch.dir_y;
              run_r[2]     <= in_ch.dir_z;
              have_first_r <= 1'b1;
            end
          end
        end
        S_XC: begin
          if (!ph_r) begin
            acc_r <= mul_p;
            ph_r  <= 1'b1;
          end else begin
            if (use_v_r) v_r[j_r] <= rnd_v;
            else         c_r[j_r] <= rnd_v;
            ph_r <= 1'b0;
            j_r  <= (j_r == 2'd2) ? 2'd0 : j_r + 2'd1;
            if (j_r == 2'd2) begin
              // the length from the first pass is the divisor of the second
              if (!use_v_r) len_r <= '0;
              nsum_r <= '0;
            end
          end
        end
        S_LEN: begin
          len_r <= len_sum[LW] ? '1 : len_sum[LW-1:0];
          j_r   <= (j_r == 2'd2) ? 2'd0 : j_r + 2'd1;
        end
        S_DEC: begin
          if (len_r <= {1'b0, plim_r}) begin
            // parallel: nothing more here
          end else if (len_r <= {1'b0, slim_r} || len_r == '0) begin
            fail_seen_r <= 1'b1;
          end else begin
            if (c_clip != '0) clip_seen_r <= 1'b1;
            use_v_r <= 1'b1;
            j_r     <= 2'd0;
            ph_r    <= 1'b0;
          end
        end
        S_MID: begin
          for (int k = 0; k < 3; k++) run_r[k] <= mid[k][DW-1:0];
        end
        S_NUM: begin
          if (!ph_r) begin
            acc_r <= mul_p;
            ph_r  <= 1'b1;
          end else begin
            nsum_r <= nsum_r + NW'(rnd_v);
            ph_r   <= 1'b0;
            j_r    <= (j_r == 2'd2) ? 2'd0 : j_r + 2'd1;
            if (j_r == 2'd2) begin
              cnt_r  <= 2'd0;
              xacc_r <= XAW'(len_r >> 1);
            end
          end
        end
        S_DP: begin
          xacc_r <= xacc_r + part;
          cnt_r  <= cnt_r + 2'd1;
        end
        S_DW: begin
          if (div_stat.done) begin
            nx_r[j_r] <= upd_clip ? (upd[DW+9] ? {1'b1, {(DW-1){1'b0}}}
                                               : {1'b0, {(DW-1){1'b1}}})
                                  : upd[DW-1:0];
            if (upd_clip) clip_seen_r <= 1'b1;
            j_r    <= (j_r == 2'd2) ? 2'd0 : j_r + 2'd1;
            cnt_r  <= 2'd0;
            xacc_r <= XAW'(len_r >> 1);
          end
        end
        S_CMT: begin
          for (int k = 0; k < 3; k++) run_r[k] <= nx_r[k];
        end
        S_OUT: begin
          if (out_free) begin
            for (int k = 0; k < 3; k++) avg_r[k] <= run_r[k];
            failed_r     <= fail_seen_r;
            saturated_r  <= clip_seen_r;
            have_first_r <= 1'b0;
            fail_seen_r  <= 1'b0;
            clip_seen_r  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.avg_x     = avg_r[0];
  assign out_ch.avg_y     = avg_r[1];
  assign out_ch.avg_z     = avg_r[2];
  assign out_ch.failed    = failed_r;
  assign out_ch.saturated = saturated_r;

endmodule
`default_nettype wire

[rtl/core/dpa_check.sv]
// port-level checks for the director averaging block, bound to the top level
`default_nettype none
module dpa_check (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_x,
  input wire logic cfg_pready
);

  // output slot is empty straight after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a result that is not taken holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x))
    else $error("result dropped or changed while stalled");

  // a new result only appears while the sequencer is busy
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a transaction in flight");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port stalled");

endmodule

bind director_pair_averaging dpa_check u_dpa_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_x      (out_ch.avg_x),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

[sim/director_pair_averaging_test.sv]
// self-checking testbench for the running director averaging block
`timescale 1ns / 100ps
module director_pair_averaging_test;
  import dpa_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               failed;
    logic               saturated;
  } avg_result_t;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [AW-1:0] cfg_paddr = '0;
  logic [PDW-1:0] cfg_pwdata = '0;
  logic [PDW-1:0] cfg_prdata;
  logic cfg_pready;

  dpa_in_if  in_ch ();
  dpa_out_if out_ch ();

  director_pair_averaging dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // every input known from time zero
  initial begin
    in_ch.valid = 1'b0;
    in_ch.dir_x = '0;
    in_ch.dir_y = '0;
    in_ch.dir_z = '0;
    in_ch.last_dir = 1'b0;
    out_ch.ready = 1'b0;
  end

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor copy of the block state and thresholds
  logic [LIMW-1:0]    par_lim;
  logic [LIMW-1:0]    sing_lim;
  logic signed [31:0] dir_run [3];
  logic               have_first;
  logic               fail_seen;
  logic               clip_seen;

  avg_result_t averages_due [$];
  int  errors = 0;
  longint cycles = 0;

  // idle knobs
  logic no_idle = 1'b0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  function automatic wide_t round_frac(input wide_t x);
    return (x + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic wide_t magn(input wide_t x);
    return x < 0 ? -x : x;
  endfunction

  function automatic wide_t square_sat(input wide_t x);
    wide_t m;
    m = magn(x);
    return m > wide_t'(64'hFFFF_FFFF) ? wide_t'(64'hFFFF_FFFF_FFFF_FFFF) : m * m;
  endfunction

  function automatic wide_t clip_dir(input wide_t x);
    if (x > wide_t'(32'sh7FFF_FFFF)) begin
      clip_seen = 1'b1;
      return wide_t'(32'sh7FFF_FFFF);
    end
    if (x < -wide_t'(64'h8000_0000)) begin
      clip_seen = 1'b1;
      return -wide_t'(64'h8000_0000);
    end
    return x;
  endfunction

  // advance the running director by one vector
  task automatic fold_director(input wide_t d [3]);
    wide_t a [3];
    wide_t c [3];
    wide_t cs [3];
    wide_t v [3];
    wide_t nx [3];
    wide_t nsum, len, q, num, pl, sl;
    logic neg;
    for (int k = 0; k < 3; k++) a[k] = dir_run[k];
    c[0] = round_frac(a[1] * d[2] - a[2] * d[1]);
    c[1] = round_frac(a[2] * d[0] - a[0] * d[2]);
    c[2] = round_frac(a[0] * d[1] - a[1] * d[0]);
    len = square_sat(c[0]) + square_sat(c[1]) + square_sat(c[2]);
    if (len > wide_t'(64'hFFFF_FFFF_FFFF_FFFF)) len = wide_t'(64'hFFFF_FFFF_FFFF_FFFF);
    pl = par_lim;
    sl = sing_lim;
    if (len <= pl) begin
      // near parallel: midpoint, floor
      for (int k = 0; k < 3; k++) nx[k] = (a[k] + d[k]) >>> 1;
    end else if (len <= sl || len == 0) begin
      // singular denominator leaves the director alone
      fail_seen = 1'b1;
      return;
    end else begin
      for (int k = 0; k < 3; k++) cs[k] = clip_dir(c[k]);
      v[0] = round_frac(a[1] * cs[2] - a[2] * cs[1]);
      v[1] = round_frac(a[2] * cs[0] - a[0] * cs[2]);
      v[2] = round_frac(a[0] * cs[1] - a[1] * cs[0]);
      nsum = 0;
      for (int k = 0; k < 3; k++) nsum += round_frac(a[k] * d[k] - d[k] * d[k]);
      for (int k = 0; k < 3; k++) begin
        num = (magn(nsum) * magn(v[k])) <<< FRAC_BITS;
        q = (num + (len >>> 1)) / len;
        if (q > (wide_t'(1) <<< 40)) q = wide_t'(1) <<< 40;
        neg = (nsum < 0) != (v[k] < 0);
        nx[k] = clip_dir(a[k] + (neg ? -q : q));
      end
    end
    for (int k = 0; k < 3; k++) dir_run[k] = nx[k][31:0];
  endtask

  task automatic predict_director(input logic signed [31:0] x, y, z, input logic last);
    wide_t d [3];
    avg_result_t r;
    d[0] = x;
    d[1] = y;
    d[2] = z;
    if (!have_first) begin
      dir_run[0] = x;
      dir_run[1] = y;
      dir_run[2] = z;
      have_first = 1'b1;
    end else begin
      fold_director(d);
    end
    if (last) begin
      r.x = dir_run[0];
      r.y = dir_run[1];
      r.z = dir_run[2];
      r.failed = fail_seen;
      r.saturated = clip_seen;
      averages_due.push_back(r);
      have_first = 1'b0;
      fail_seen = 1'b0;
      clip_seen = 1'b0;
    end
  endtask

  // one director transaction; entered and left just after a rising edge
  task automatic send_dir(input logic signed [31:0] x, y, z, input logic last);
    logic rdy;
    if (!no_idle && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.dir_x <= x;
    in_ch.dir_y <= y;
    in_ch.dir_z <= z;
    in_ch.last_dir <= last;
    // ready only moves at a rising edge, so the falling edge shows what the next edge sees
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    predict_director(x, y, z, last);
  endtask

  task automatic write_reg(input logic [AW-1:0] addr, input logic [PDW-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == REG_PARALLEL) par_lim = data[LIMW-1:0];
    else if (addr == REG_SINGULAR) sing_lim = data[LIMW-1:0];
  endtask

  task automatic wait_drained;
    in_ch.valid <= 1'b0;
    while (averages_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limits(input logic [LIMW-1:0] par, sing);
    wait_drained();
    write_reg(REG_PARALLEL, {1'b0, par});
    write_reg(REG_SINGULAR, {1'b0, sing});
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
      2: return $signed($urandom_range(2000)) - 1000;
      default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  // a run: mostly unit-ish directors, some near the previous one, some wild
  task automatic send_run(input int len_max);
    int n;
    logic signed [31:0] x, y, z;
    int sh;
    n = $urandom_range(1, len_max);
    x = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
    y = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
    z = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: begin
          x = rand_word();
          y = rand_word();
          z = rand_word();
        end
        2, 3, 4: begin
          sh = $urandom_range(4, 20);
          x = x + ($signed($urandom) >>> (31 - sh));
          y = y + ($signed($urandom) >>> (31 - sh));
          z = z + ($signed($urandom) >>> (31 - sh));
        end
        default: begin
          x = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
          y = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
          z = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
        end
      endcase
      send_dir(x, y, z, i == n - 1);
    end
  endtask

  // result side: ready moves at the rising edge, with long hold-offs on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 600;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  // valid, ready and payload are steady at the falling edge, so a transaction seen here
  // completes at the next rising edge
  always @(negedge clk) begin
    avg_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.x = out_ch.avg_x;
      got.y = out_ch.avg_y;
      got.z = out_ch.avg_z;
      got.failed = out_ch.failed;
      got.saturated = out_ch.saturated;
      if (averages_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = averages_due.pop_front();
        if (got.x !== want.x) begin
          $display("%0t avg_x: expected %h, actual %h", $time, want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t avg_y: expected %h, actual %h", $time, want.y, got.y);
          errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t avg_z: expected %h, actual %h", $time, want.z, got.z);
          errors++;
        end
        if (got.failed !== want.failed) begin
          $display("%0t failed: expected %b, actual %b", $time, want.failed, got.failed);
          errors++;
        end
        if (got.saturated !== want.saturated) begin
          $display("%0t saturated: expected %b, actual %b", $time, want.saturated,
                   got.saturated);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("director_pair_averaging test failed");
      $finish;
    end
  end

  // single vector comes back as sent, extremes included
  task automatic test_run_of_one;
    send_dir(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_dir(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_dir(32'sh4000_0000, 0, -32'sh4000_0000, 1'b1);
    send_dir(0, 0, 0, 1'b1);
  endtask

  // parallel midpoints, orthogonal general steps and clipping
  task automatic test_directed_steps;
    send_dir(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_dir(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_dir(32'sh7FFF_FFFF, 0, 0, 1'b0);
    send_dir(32'sh8000_0000, 0, 0, 1'b1);
    send_dir(32'sh4000_0000, 0, 0, 1'b0);
    send_dir(0, 32'sh4000_0000, 0, 1'b0);
    send_dir(0, 0, 32'sh4000_0000, 1'b1);
    send_dir(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_dir(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_dir(0, 0, 0, 1'b0);
    send_dir(32'sh3000_0000, 32'sh1000_0000, 32'sh2000_0000, 1'b1);
    send_dir(32'sh4000_0000, 32'sh0000_0400, 0, 1'b0);
    send_dir(32'sh4000_0000, 0, 32'sh0000_0400, 1'b1);
  endtask

  // everything above the parallel limit fails when the singular limit is huge
  task automatic test_singular;
    set_limits('0, {1'b0, {62{1'b1}}});
    send_dir(32'sh4000_0000, 0, 0, 1'b0);
    send_dir(0, 32'sh4000_0000, 0, 1'b0);
    send_dir(32'sh4000_0000, 0, 0, 1'b1);
    // limits in odd order: nothing can fail
    set_limits({1'b0, {62{1'b1}}}, '0);
    send_dir(32'sh4000_0000, 0, 0, 1'b0);
    send_dir(0, 32'sh4000_0000, 0, 1'b1);
    set_limits({LIMW{1'b1}}, {LIMW{1'b1}});
    send_dir(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1'b0);
    send_dir(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    set_limits('0, '0);
    send_dir(32'sh4000_0000, 0, 0, 1'b0);
    send_dir(0, 32'sh4000_0000, 0, 1'b1);
  endtask

  // random runs under several threshold settings
  task automatic test_random_runs(input int items);
    int sent;
    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_limits(PARALLEL_RST, SINGULAR_RST);
        1: set_limits(LIMW'(64'h0010_0000_0000_0000), LIMW'(64'h0100_0000_0000_0000));
        2: set_limits(LIMW'({$urandom, $urandom} >> 1),
                      LIMW'({$urandom, $urandom} >> ($urandom_range(1, 40))));
        default: set_limits(LIMW'($urandom_range(1 << 20)), '0);
      endcase
      no_idle = (phase == 0);
      while (sent < items * (phase + 1) / 4) begin
        send_run(6);
        sent = sent + 1;
        if ($urandom_range(15) == 0) begin
          // sender waits until every result is back
          in_ch.valid <= 1'b0;
          while (averages_due.size() != 0) @(posedge clk);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure;
    set_limits(PARALLEL_RST, SINGULAR_RST);
    hold_req++;
    for (int i = 0; i < 12; i++) send_run(2);
  endtask

  initial begin
    par_lim = PARALLEL_RST;
    sing_lim = SINGULAR_RST;
    have_first = 1'b0;
    fail_seen = 1'b0;
    clip_seen = 1'b0;
    for (int k = 0; k < 3; k++) dir_run[k] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_run_of_one();
    test_directed_steps();
    test_singular();
    test_backpressure();
    test_random_runs(230);
    in_ch.valid <= 1'b0;
    while (averages_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("director_pair_averaging test passed");
    end else begin
      $display("director_pair_averaging test failed");
    end
    $finish;
  end

endmodule

[director_pair_averaging.f]
rtl/core/dpa_pkg.sv
rtl/core/dpa_in_if.sv
rtl/core/dpa_out_if.sv
rtl/core/dpa_div.sv
rtl/core/director_pair_averaging.sv
rtl/core/dpa_check.sv
sim/director_pair_averaging_test.sv
